/* sv/sfd_pkg.sv */
// package: shared types and constants of the stereo feedback delay
package sfd_pkg;

	localparam int MAX_DELAY_DEF   = 131072;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int DELAY_W         = 17;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 17;
	localparam logic [14:0] FB_CAP = 15'd31129;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_L = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_R = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WET     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd6;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_DAMP, ST_DSTO, ST_FB, ST_FBSTO,
		ST_FBG, ST_WR, ST_OUTD, ST_OUTW, ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic read;
		logic damp;
		logic damp_store;
		logic fb;
		logic fb_store;
		logic fb_gain;
		logic write;
		logic out_dry;
		logic out_wet;
		logic bypass;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic enabled;
	} sts_t;

endpackage

/* sv/sfd_if.sv */
// interfaces: sample channel and configuration write channel
interface sfd_stream_if #(parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left;
	logic signed [SAMPLE_BITS-1:0] right;
	modport source (output valid, left, right, input ready);
	modport sink (input valid, left, right, output ready);
endinterface

interface sfd_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sfd_pkg::CFG_IDX_W-1:0]        index;
	logic [sfd_pkg::CFG_DATA_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/sfd_ctrl.sv */
// controller: sequences one sample pair through the shared datapath
module sfd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  sfd_pkg::sts_t   sts,
	output sfd_pkg::cmd_t   cmd
);
	sfd_pkg::state_t state_q, state_nx;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			sfd_pkg::ST_CLEAR: if (sts.clear_done) state_nx = sfd_pkg::ST_IDLE;
			sfd_pkg::ST_IDLE: begin
				if (in_valid) state_nx = sts.enabled ? sfd_pkg::ST_READ : sfd_pkg::ST_DONE;
			end
			sfd_pkg::ST_READ:  state_nx = sfd_pkg::ST_DAMP;
			sfd_pkg::ST_DAMP:  state_nx = sfd_pkg::ST_DSTO;
			sfd_pkg::ST_DSTO:  state_nx = sfd_pkg::ST_FB;
			sfd_pkg::ST_FB:    state_nx = sfd_pkg::ST_FBSTO;
			sfd_pkg::ST_FBSTO: state_nx = sfd_pkg::ST_FBG;
			sfd_pkg::ST_FBG:   state_nx = sfd_pkg::ST_WR;
			sfd_pkg::ST_WR:    state_nx = sfd_pkg::ST_OUTD;
			sfd_pkg::ST_OUTD:  state_nx = sfd_pkg::ST_OUTW;
			sfd_pkg::ST_OUTW:  state_nx = sfd_pkg::ST_DONE;
			sfd_pkg::ST_DONE: begin
				if (out_ready) state_nx = sfd_pkg::ST_IDLE;
			end
			default: state_nx = sfd_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		in_ready   = (state_q == sfd_pkg::ST_IDLE);
		out_valid  = (state_q == sfd_pkg::ST_DONE);
		cmd.capture    = in_ready && in_valid;
		cmd.bypass     = !sts.enabled;
		cmd.clr_wr     = (state_q == sfd_pkg::ST_CLEAR);
		cmd.read       = (state_q == sfd_pkg::ST_READ);
		cmd.damp       = (state_q == sfd_pkg::ST_DAMP);
		cmd.damp_store = (state_q == sfd_pkg::ST_DSTO);
		cmd.fb         = (state_q == sfd_pkg::ST_FB);
		cmd.fb_store   = (state_q == sfd_pkg::ST_FBSTO);
		cmd.fb_gain    = (state_q == sfd_pkg::ST_FBG);
		cmd.write      = (state_q == sfd_pkg::ST_WR);
		cmd.out_dry    = (state_q == sfd_pkg::ST_OUTD);
		cmd.out_wet    = (state_q == sfd_pkg::ST_OUTW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sfd_pkg::ST_CLEAR;
		else state_q <= state_nx;
	end

	// an accepted item moves the controller out of idle
	a_accept_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != sfd_pkg::ST_IDLE)
		else $error("accepted item lost");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("accept while result pending");
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfd_pkg::ST_CLEAR |-> !in_ready)
		else $error("accept during clear");
endmodule

/* sv/sfd_dp.sv */
// datapath: delay memories, damping states, shared products and saturation
module sfd_dp #(
	parameter int MAX_DELAY   = sfd_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sfd_pkg::cmd_t                        cmd,
	output sfd_pkg::sts_t                        sts,
	input  logic signed [SAMPLE_BITS-1:0]        in_l,
	input  logic signed [SAMPLE_BITS-1:0]        in_r,
	input  logic [sfd_pkg::DELAY_W-1:0]          dly_l,
	input  logic [sfd_pkg::DELAY_W-1:0]          dly_r,
	input  logic [14:0]                          fbg_raw,
	input  logic [14:0]                          dmp,
	input  logic [15:0]                          wet,
	input  logic [15:0]                          dry,
	input  logic [2:0]                           mode,
	output logic signed [SAMPLE_BITS-1:0]        out_l,
	output logic signed [SAMPLE_BITS-1:0]        out_r
);
	localparam int AW = $clog2(MAX_DELAY);
	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + 19;
	localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SB - 1)) - 1);
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
	localparam logic [AW:0] MAXD = (AW+1)'(MAX_DELAY);

	function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
		if (v > SMAX) return SB'(SMAX);
		if (v < SMIN) return SB'(SMIN);
		return SB'(v);
	endfunction

	logic signed [SB-1:0] mem_l [MAX_DELAY];
	logic signed [SB-1:0] mem_r [MAX_DELAY];
	logic [AW-1:0]        wp_q;
	logic [AW:0]          clr_q;
	logic signed [SB-1:0] inl_q, inr_q, dl_q, dr_q, sl_q, sr_q, fl_q, fr_q;
	logic signed [SB-1:0] ol_q, or_q;
	logic signed [PW-1:0] pdl_q, pdr_q;
	logic signed [PW-1:0] pa_s1, pb_s1;
	logic [14:0]          fbg;
	logic signed [SB-1:0] src_r;
	logic [AW-1:0]        ra_l, ra_r;

	// effective delay and read address
	function automatic logic [AW-1:0] raddr(input logic [sfd_pkg::DELAY_W-1:0] d,
		input logic [AW-1:0] w);
		logic [AW:0] e;
		logic [AW+1:0] s;
		e = ((d == '0) || ((AW+1+sfd_pkg::DELAY_W)'(d) > (AW+1+sfd_pkg::DELAY_W)'(MAXD)))
			? MAXD : (AW+1)'(d);
		s = (AW+2)'(w) + (AW+2)'(MAXD) - (AW+2)'(e);
		if (s >= (AW+2)'(MAXD)) s = s - (AW+2)'(MAXD);
		return s[AW-1:0];
	endfunction

	assign ra_l  = raddr(dly_l, wp_q);
	assign ra_r  = raddr(dly_r, wp_q);
	assign fbg   = (fbg_raw > sfd_pkg::FB_CAP) ? sfd_pkg::FB_CAP : fbg_raw;
	assign src_r = mode[1] ? inr_q : inl_q;
	assign sts.clear_done = (clr_q == MAXD);
	assign sts.enabled    = mode[2];
	assign out_l = ol_q;
	assign out_r = or_q;

	// rounded products, one step at a time through shared multipliers
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p, input int sh);
		return (p + (PW'(1) <<< (sh - 1))) >>> sh;
	endfunction

	logic signed [PW-1:0] ma_a, ma_b, mb_a, mb_b;
	always_comb begin
		ma_a = '0; ma_b = '0; mb_a = '0; mb_b = '0;
		if (cmd.damp) begin
			ma_a = PW'(dmp); ma_b = PW'(dl_q) - PW'(sl_q);
			mb_a = PW'(dmp); mb_b = PW'(dr_q) - PW'(sr_q);
		end else if (cmd.fb) begin
			ma_a = PW'(sl_q); ma_b = PW'(dmp);
			mb_a = PW'(sr_q); mb_b = PW'(dmp);
		end else if (cmd.fb_gain) begin
			ma_a = PW'(mode[0] ? fr_q : fl_q); ma_b = PW'(fbg);
			mb_a = PW'(mode[0] ? fl_q : fr_q); mb_b = PW'(fbg);
		end else if (cmd.write) begin
			ma_a = PW'(inl_q); ma_b = PW'(dry);
			mb_a = PW'(inr_q); mb_b = PW'(dry);
		end else begin
			ma_a = mode[1] ? PW'(dl_q) : PW'(dl_q) + PW'(dr_q); ma_b = PW'(wet);
			mb_a = PW'(dr_q); mb_b = PW'(wet);
		end
	end

	always_ff @(posedge clk) begin
		pa_s1 <= ma_a * ma_b;
		pb_s1 <= mb_a * mb_b;
	end

	// memory writes: clearing pass after reset, then one write per item when enabled
	always_ff @(posedge clk) begin
		if (cmd.clr_wr && !sts.clear_done) begin
			mem_l[clr_q[AW-1:0]] <= '0;
			mem_r[clr_q[AW-1:0]] <= '0;
		end else if (cmd.write) begin
			mem_l[wp_q] <= sat(PW'(inl_q) + rnd(pa_s1, 15));
			mem_r[wp_q] <= sat(PW'(src_r) + rnd(pb_s1, 15));
		end
		if (cmd.read) begin
			dl_q <= mem_l[ra_l];
			dr_q <= mem_r[ra_r];
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			inl_q <= in_l;
			inr_q <= in_r;
			if (cmd.bypass) begin
				ol_q <= in_l;
				or_q <= in_r;
			end
		end
		if (cmd.fb_store) begin
			fl_q <= sat(PW'(dl_q) - rnd(pa_s1, 15));
			fr_q <= sat(PW'(dr_q) - rnd(pb_s1, 15));
		end
		// dry part kept at full width until the wet part is added
		if (cmd.out_wet) begin
			ol_q <= sat(pdl_q + rnd(pa_s1, mode[1] ? 15 : 16));
			or_q <= mode[1] ? sat(pdr_q + rnd(pb_s1, 15)) : inr_q;
		end else if (cmd.out_dry) begin
			pdl_q <= rnd(pa_s1, 15);
			pdr_q <= rnd(pb_s1, 15);
		end
	end

	// control state: pointers and damping states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			clr_q <= '0;
			sl_q  <= '0;
			sr_q  <= '0;
		end else begin
			if (cmd.clr_wr && !sts.clear_done) clr_q <= clr_q + 1'b1;
			if (cmd.write) wp_q <= (wp_q == AW'(MAX_DELAY - 1)) ? '0 : wp_q + 1'b1;
			if (cmd.damp_store) begin
				sl_q <= sat(PW'(sl_q) + rnd(pa_s1, 15));
				sr_q <= sat(PW'(sr_q) + rnd(pb_s1, 15));
			end
		end
	end

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < MAX_DELAY) else $error("write position out of range");
	a_clr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q <= MAXD) else $error("clear count overrun");
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> wp_q != $past(wp_q)) else $error("write position stuck");
endmodule

/* sv/stereo_feedback_delay.sv */
// top level: stereo feedback delay with damped feedback and optional ping-pong cross-feed
// enabled: an item goes through read, damping, feedback, feedback gain, write, dry and wet
// output steps; bypass: the input is registered to the output; a new item is taken only
// after the last result has been taken; the configuration channel is always ready
// reset: control and configuration registers reset; then a clearing pass zeroes both
// delay memories, during which no item is taken
module stereo_feedback_delay #(
	parameter int MAX_DELAY   = sfd_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfd_stream_if.sink   in_ch,
	sfd_stream_if.source out_ch,
	sfd_cfg_if.sink      cfg
);
	logic [16:0] dly_l_q, dly_r_q;
	logic [14:0] fbg_q, dmp_q;
	logic [15:0] wet_q, dry_q;
	logic [2:0]  mode_q;
	sfd_pkg::cmd_t cmd;
	sfd_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_l_q <= 17'd18000;
			dly_r_q <= 17'd18000;
			fbg_q   <= 15'd13107;
			dmp_q   <= 15'd5898;
			wet_q   <= 16'd9830;
			dry_q   <= 16'd22938;
			mode_q  <= 3'd6;
		end else if (cfg.valid) begin
			case (cfg.index)
				sfd_pkg::REG_DELAY_L: dly_l_q <= cfg.data;
				sfd_pkg::REG_DELAY_R: dly_r_q <= cfg.data;
				sfd_pkg::REG_FB_GAIN: fbg_q   <= cfg.data[14:0];
				sfd_pkg::REG_DAMPING: dmp_q   <= cfg.data[14:0];
				sfd_pkg::REG_WET:     wet_q   <= cfg.data[15:0];
				sfd_pkg::REG_DRY:     dry_q   <= cfg.data[15:0];
				sfd_pkg::REG_MODE:    mode_q  <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	sfd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	sfd_dp #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_l(in_ch.left), .in_r(in_ch.right),
		.dly_l(dly_l_q), .dly_r(dly_r_q), .fbg_raw(fbg_q), .dmp(dmp_q),
		.wet(wet_q), .dry(dry_q), .mode(mode_q),
		.out_l(out_ch.left), .out_r(out_ch.right)
	);
endmodule
